// ----- rtl/core/alex_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arithmetic expression lexer package
// Token kinds, character classes, lexer modes and the queue item format
// shared by the front end, the queue and the token engine.
// ----------------------------------------------------------------------------
package alex_pkg;

   localparam int unsigned KIND_W  = 4;
   localparam int unsigned VALUE_W = 31;
   localparam int unsigned POS_W   = 16;
   localparam int unsigned LEN_W   = 8;

   localparam logic [KIND_W-1:0] KIND_INT       = 4'd0;
   localparam logic [KIND_W-1:0] KIND_PLUS      = 4'd1;
   localparam logic [KIND_W-1:0] KIND_MINUS     = 4'd2;
   localparam logic [KIND_W-1:0] KIND_MUL       = 4'd3;
   localparam logic [KIND_W-1:0] KIND_DIV       = 4'd4;
   localparam logic [KIND_W-1:0] KIND_LPAREN    = 4'd5;
   localparam logic [KIND_W-1:0] KIND_RPAREN    = 4'd6;
   localparam logic [KIND_W-1:0] KIND_ASSIGN    = 4'd7;
   localparam logic [KIND_W-1:0] KIND_SEMICOLON = 4'd8;
   localparam logic [KIND_W-1:0] KIND_IDENT     = 4'd9;
   localparam logic [KIND_W-1:0] KIND_END       = 4'd10;
   localparam logic [KIND_W-1:0] KIND_ERROR     = 4'd11;

   localparam logic [VALUE_W-1:0] VALUE_MAX = 31'h7FFF_FFFF;
   localparam logic [LEN_W-1:0]   LEN_MAX   = 8'hFF;

   typedef enum logic [2:0] {
      CLASS_SEP     = 3'd0,
      CLASS_DIGIT   = 3'd1,
      CLASS_LETTER  = 3'd2,
      CLASS_SYMBOL  = 3'd3,
      CLASS_ILLEGAL = 3'd4,
      CLASS_EOT     = 3'd5
   } alex_class_type;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'b001,
      MODE_INT   = 3'b010,
      MODE_IDENT = 3'b100
   } alex_mode_type;

   typedef struct packed {
      alex_class_type     cls;
      logic [3:0]         digit;
      logic [KIND_W-1:0]  sym_kind;
      logic [POS_W-1:0]   line;
      logic [POS_W-1:0]   column;
   } alex_item_type;

endpackage

// ----- rtl/core/alex_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer channel interfaces
// Valid/ready channels for incoming characters and outgoing tokens.
// ----------------------------------------------------------------------------
interface alex_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  ch;
   logic        end_of_text;
   logic [15:0] line;
   logic [15:0] column;

   modport source (output valid, ch, end_of_text, line, column, input ready);
   modport sink   (input valid, ch, end_of_text, line, column, output ready);
endinterface

interface alex_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  kind;
   logic [30:0] value;
   logic [15:0] start_line;
   logic [15:0] start_column;
   logic [7:0]  length;
   logic        overflow;
   logic        last;

   modport source (output valid, kind, value, start_line, start_column, length,
                   overflow, last, input ready);
   modport sink   (input valid, kind, value, start_line, start_column, length,
                   overflow, last, output ready);
endinterface

// ----- rtl/core/alex_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer front end
// Accepts characters and sorts each into a class before it is queued.
// ----------------------------------------------------------------------------
module alex_front
   import alex_pkg::*;
(
   alex_req_if.sink        req_chan,
   input  logic            queue_full,
   output logic            push_valid,
   output alex_item_type   push_item
);

   logic [7:0] c;

   assign c = req_chan.ch;
   assign req_chan.ready = !queue_full;
   assign push_valid     = req_chan.valid && !queue_full;

   always_comb begin
      push_item.digit    = c[3:0];
      push_item.sym_kind = KIND_INT;
      push_item.line     = req_chan.line;
      push_item.column   = req_chan.column;
      if (req_chan.end_of_text) begin
         push_item.cls = CLASS_EOT;
      end else begin
         case (c) inside
            8'h20, 8'h09, 8'h0A:         push_item.cls = CLASS_SEP;
            ["0":"9"]:                   push_item.cls = CLASS_DIGIT;
            ["A":"Z"], ["a":"z"]:        push_item.cls = CLASS_LETTER;
            "+", "-", "*", "/", "(", ")", "=", ";":
                                         push_item.cls = CLASS_SYMBOL;
            default:                     push_item.cls = CLASS_ILLEGAL;
         endcase
      end
      case (c)
         "+":     push_item.sym_kind = KIND_PLUS;
         "-":     push_item.sym_kind = KIND_MINUS;
         "*":     push_item.sym_kind = KIND_MUL;
         "/":     push_item.sym_kind = KIND_DIV;
         "(":     push_item.sym_kind = KIND_LPAREN;
         ")":     push_item.sym_kind = KIND_RPAREN;
         "=":     push_item.sym_kind = KIND_ASSIGN;
         ";":     push_item.sym_kind = KIND_SEMICOLON;
         default: push_item.sym_kind = KIND_INT;
      endcase
   end

endmodule

// ----- rtl/core/alex_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer item queue
// Small register queue between the front end and the token engine.
// ----------------------------------------------------------------------------
module alex_queue
   import alex_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)(
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   input  alex_item_type   push_item,
   output logic            full,
   output logic            pop_valid,
   output alex_item_type   pop_item,
   input  logic            pop_ready
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   alex_item_type    store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign pop_valid = (count_ff != '0);
   assign pop_item  = store_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/core/alex_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer token engine
// Runs the idle/integer/identifier automaton over classified characters and
// drives the registered token output.
// ----------------------------------------------------------------------------
module alex_back
   import alex_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  alex_item_type   head,
   output logic            head_pop,
   alex_rsp_if.source      rsp_chan
);

   alex_mode_type       mode_ff, mode_in;
   logic [VALUE_W-1:0]  acc_ff, acc_in;
   logic [POS_W-1:0]    tok_line_ff, tok_line_in;
   logic [POS_W-1:0]    tok_col_ff, tok_col_in;
   logic [LEN_W-1:0]    tok_len_ff, tok_len_in;
   logic                tok_ovf_ff, tok_ovf_in;
   // Set while the current item still owes its second token.
   logic                second_ff, second_in;

   logic                rsp_valid_ff;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [POS_W-1:0]    rsp_line_ff, rsp_line_in;
   logic [POS_W-1:0]    rsp_col_ff, rsp_col_in;
   logic [LEN_W-1:0]    rsp_len_ff, rsp_len_in;
   logic                rsp_ovf_ff, rsp_ovf_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                out_free, fire, emit;
   logic                is_digit, is_letter, idle_emits;
   logic                continue_tok, close_tok;
   logic [VALUE_W+3:0]  acc_next;
   logic [LEN_W-1:0]    len_next;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign fire       = head_valid && out_free;
   assign is_digit   = (head.cls == CLASS_DIGIT);
   assign is_letter  = (head.cls == CLASS_LETTER);
   assign idle_emits = (head.cls == CLASS_SYMBOL) || (head.cls == CLASS_ILLEGAL) ||
                       (head.cls == CLASS_EOT);

   assign continue_tok = !second_ff && head.cls != CLASS_EOT &&
                         ((mode_ff == MODE_INT && is_digit) ||
                          (mode_ff == MODE_IDENT && is_letter));
   assign close_tok    = !second_ff && (mode_ff != MODE_IDLE) && !continue_tok;

   // acc * 10 + digit as two shifts and two adds.
   assign acc_next = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) +
                     {(VALUE_W)'(0), head.digit};
   assign len_next = (tok_len_ff == LEN_MAX) ? tok_len_ff : tok_len_ff + 1'b1;

   always_comb begin
      mode_in     = mode_ff;
      acc_in      = acc_ff;
      tok_line_in = tok_line_ff;
      tok_col_in  = tok_col_ff;
      tok_len_in  = tok_len_ff;
      tok_ovf_in  = tok_ovf_ff;
      second_in   = second_ff;
      head_pop    = 1'b0;
      emit        = 1'b0;

      rsp_kind_in  = KIND_END;
      rsp_value_in = '0;
      rsp_line_in  = head.line;
      rsp_col_in   = head.column;
      rsp_len_in   = '0;
      rsp_ovf_in   = 1'b0;
      rsp_last_in  = 1'b1;

      if (fire) begin
         if (continue_tok) begin
            head_pop   = 1'b1;
            tok_len_in = len_next;
            if (mode_ff == MODE_INT) begin
               if (|acc_next[VALUE_W+3:VALUE_W]) begin
                  acc_in     = VALUE_MAX;
                  tok_ovf_in = 1'b1;
               end else begin
                  acc_in = acc_next[VALUE_W-1:0];
               end
            end
         end else begin
            if (close_tok) begin
               emit         = 1'b1;
               rsp_kind_in  = (mode_ff == MODE_INT) ? KIND_INT : KIND_IDENT;
               rsp_value_in = (mode_ff == MODE_INT) ? acc_ff : '0;
               rsp_ovf_in   = (mode_ff == MODE_INT) ? tok_ovf_ff : 1'b0;
               rsp_line_in  = tok_line_ff;
               rsp_col_in   = tok_col_ff;
               rsp_len_in   = tok_len_ff;
               rsp_last_in  = !idle_emits;
               mode_in      = MODE_IDLE;
               acc_in       = '0;
               tok_line_in  = '0;
               tok_col_in   = '0;
               tok_len_in   = '0;
               tok_ovf_in   = 1'b0;
            end
            if (close_tok && idle_emits) begin
               // Output slot is taken; the item's own token goes out next.
               second_in = 1'b1;
            end else begin
               head_pop  = 1'b1;
               second_in = 1'b0;
               case (head.cls)
                  CLASS_SEP: begin
                  end
                  CLASS_DIGIT: begin
                     mode_in     = MODE_INT;
                     acc_in      = {(VALUE_W-4)'(0), head.digit};
                     tok_line_in = head.line;
                     tok_col_in  = head.column;
                     tok_len_in  = 8'd1;
                     tok_ovf_in  = 1'b0;
                  end
                  CLASS_LETTER: begin
                     mode_in     = MODE_IDENT;
                     acc_in      = '0;
                     tok_line_in = head.line;
                     tok_col_in  = head.column;
                     tok_len_in  = 8'd1;
                     tok_ovf_in  = 1'b0;
                  end
                  CLASS_SYMBOL: begin
                     emit        = 1'b1;
                     rsp_kind_in = head.sym_kind;
                     rsp_len_in  = 8'd1;
                  end
                  CLASS_ILLEGAL: begin
                     emit        = 1'b1;
                     rsp_kind_in = KIND_ERROR;
                     rsp_len_in  = 8'd1;
                  end
                  CLASS_EOT: begin
                     emit        = 1'b1;
                     rsp_kind_in = KIND_END;
                     mode_in     = MODE_IDLE;
                     acc_in      = '0;
                     tok_line_in = '0;
                     tok_col_in  = '0;
                     tok_len_in  = '0;
                     tok_ovf_in  = 1'b0;
                  end
                  default: begin
                     emit        = 1'b1;
                     rsp_kind_in = KIND_ERROR;
                     rsp_len_in  = 8'd1;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         acc_ff       <= '0;
         tok_line_ff  <= '0;
         tok_col_ff   <= '0;
         tok_len_ff   <= '0;
         tok_ovf_ff   <= 1'b0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         acc_ff      <= acc_in;
         tok_line_ff <= tok_line_in;
         tok_col_ff  <= tok_col_in;
         tok_len_ff  <= tok_len_in;
         tok_ovf_ff  <= tok_ovf_in;
         second_ff   <= second_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_value_ff <= rsp_value_in;
         rsp_line_ff  <= rsp_line_in;
         rsp_col_ff   <= rsp_col_in;
         rsp_len_ff   <= rsp_len_in;
         rsp_ovf_ff   <= rsp_ovf_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = rsp_kind_ff;
   assign rsp_chan.value        = rsp_value_ff;
   assign rsp_chan.start_line   = rsp_line_ff;
   assign rsp_chan.start_column = rsp_col_ff;
   assign rsp_chan.length       = rsp_len_ff;
   assign rsp_chan.overflow     = rsp_ovf_ff;
   assign rsp_chan.last         = rsp_last_ff;

   a_second_idle: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> (mode_ff == MODE_IDLE))
      else $error("pending second token while a token is open");

   a_second_after_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(second_ff) |-> (rsp_valid_ff && !rsp_last_ff))
      else $error("second token owed without a first one");

   a_ovf_int_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ovf_ff || rsp_value_ff != '0)) |-> (rsp_kind_ff == KIND_INT))
      else $error("value or overflow on a non-integer token");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_END || rsp_kind_ff == KIND_ERROR)) |->
      rsp_last_ff)
      else $error("end or error token not marked last");

endmodule

// ----- rtl/core/arithmetic_expression_lexer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arithmetic expression lexer
// Turns a character stream into integer, identifier, symbol, end and error
// tokens with their start position, length and saturated integer value.
// ----------------------------------------------------------------------------
//  channel    dir  payload
//  req_chan   in   ch, end_of_text, line, column
//  rsp_chan   out  kind, value, start_line, start_column, length, overflow, last
//
//  One character per cycle; the engine issues one token per cycle while the
//  output is free; a character that ends a token and gives its own yields two.
//  Characters pass through a QUEUE_DEPTH-entry queue, so the input stalls
//  only when that queue is full; the output is a single register stage.
//  Reset is synchronous and returns the automaton to idle with an empty queue.
// ----------------------------------------------------------------------------
module arithmetic_expression_lexer
   import alex_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)(
   input  logic        clock,
   input  logic        reset,
   alex_req_if.sink    req_chan,
   alex_rsp_if.source  rsp_chan
);

   logic          queue_full;
   logic          push_valid;
   alex_item_type push_item;
   logic          head_valid;
   alex_item_type head_item;
   logic          head_pop;

   alex_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   alex_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop_valid  (head_valid),
      .pop_item   (head_item),
      .pop_ready  (head_pop)
   );

   alex_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head_item),
      .head_pop   (head_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
